[rtl/bdp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdp_pkg: shared definitions for the box downsample pyramid
// Field widths, register indexes, reset values and parameter defaults used by
// the pyramid top level and its RAM.
// ----------------------------------------------------------------------------
package bdp_pkg;

   // Parameter defaults for the top level.
   localparam int MAX_WIDTH_DEF    = 2048;
   localparam int MAX_HEIGHT_DEF   = 2048;
   localparam int MAX_CHANNELS_DEF = 4;
   localparam int LEVELS_DEF       = 11;
   localparam int FRAC_BITS_DEF    = 8;

   // Port field widths.
   localparam int SAMPLE_W  = 16;
   localparam int LEVEL_W   = 4;
   localparam int COLUMN_W  = 10;
   localparam int ROW_W     = 10;
   localparam int CHANNEL_W = 2;
   localparam int VALUE_W   = 24;

   // Configuration port and register widths.
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 12;
   localparam int WIDTH_REG_W    = 12;
   localparam int HEIGHT_REG_W   = 12;
   localparam int CHANNELS_REG_W = 3;
   localparam int LEVELS_REG_W   = 4;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // Register indexes.
   localparam csr_index_type REG_IMAGE_WIDTH  = csr_index_type'(0);
   localparam csr_index_type REG_IMAGE_HEIGHT = csr_index_type'(1);
   localparam csr_index_type REG_CHANNELS     = csr_index_type'(2);
   localparam csr_index_type REG_MAX_LEVELS   = csr_index_type'(3);

   // Register values after reset.
   localparam logic [WIDTH_REG_W-1:0]    RESET_IMAGE_WIDTH  = WIDTH_REG_W'(256);
   localparam logic [HEIGHT_REG_W-1:0]   RESET_IMAGE_HEIGHT = HEIGHT_REG_W'(256);
   localparam logic [CHANNELS_REG_W-1:0] RESET_CHANNELS     = CHANNELS_REG_W'(1);
   localparam logic [LEVELS_REG_W-1:0]   RESET_MAX_LEVELS   = LEVELS_REG_W'(11);

   // Address bits needed for a store of the given depth (at least one).
   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

[rtl/bdp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdp_ram: simple dual-port RAM
// One write port and one read port; the read data is registered and holds its
// value while no read is enabled.
// ----------------------------------------------------------------------------
module bdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [bdp_pkg::addr_bits(DEPTH)-1:0]     wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [bdp_pkg::addr_bits(DEPTH)-1:0]     rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   import bdp_pkg::*;

   localparam int AW = addr_bits(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]    wr_addr_in;

   assign wr_addr_in = wr_addr;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr_in] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/box_downsample_pyramid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_pyramid: streaming 2x2 box-average image pyramid
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  sample
//   rsp_      out        rsp_valid/rsp_ready  level, column, row, channel,
//                                             value, last_of_run, image_done
//   csr_      in         csr_wr_en            csr_index, csr_data
//
// An input transfer is accepted in S_IDLE and then visits S_UPDATE once for
// each level it reaches: the first level always, and one more for each level
// that completes a reduced sample and has a level above it. Each level reads
// the pair and column RAMs and then writes back the same entries.
// After reset and after each register write, a setup pass works out the sizes
// and column store offsets of up to LEVELS levels, one level at a time; no
// sample is taken meanwhile. A level with a result waits while the output
// register is full and not being taken.
// ----------------------------------------------------------------------------
module box_downsample_pyramid #(
   parameter int MAX_WIDTH    = bdp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = bdp_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_CHANNELS = bdp_pkg::MAX_CHANNELS_DEF,
   parameter int LEVELS       = bdp_pkg::LEVELS_DEF,
   parameter int FRAC_BITS    = bdp_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bdp_pkg::SAMPLE_W-1:0]      req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bdp_pkg::LEVEL_W-1:0]       rsp_level,
   output logic [bdp_pkg::COLUMN_W-1:0]      rsp_column,
   output logic [bdp_pkg::ROW_W-1:0]         rsp_row,
   output logic [bdp_pkg::CHANNEL_W-1:0]     rsp_channel,
   output logic [bdp_pkg::VALUE_W-1:0]       rsp_value,
   output logic                              rsp_last_of_run,
   output logic                              rsp_image_done,
   input  logic                              csr_wr_en,
   input  logic [bdp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdp_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bdp_pkg::*;

   localparam int COL_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
   localparam int PAIR_DEPTH = LEVELS * MAX_CHANNELS;
   localparam int XW   = addr_bits(MAX_WIDTH);
   localparam int YW   = addr_bits(MAX_HEIGHT);
   localparam int WDW  = $clog2(MAX_WIDTH + 1);
   localparam int HDW  = $clog2(MAX_HEIGHT + 1);
   localparam int CW   = addr_bits(MAX_CHANNELS);
   localparam int NCW  = $clog2(MAX_CHANNELS + 1);
   localparam int LIW  = addr_bits(LEVELS);
   localparam int LCW  = $clog2(LEVELS + 1);
   localparam int VW   = SAMPLE_W + FRAC_BITS;
   localparam int PW   = VW + 1;
   localparam int SW   = VW + 2;
   localparam int CA   = addr_bits(COL_DEPTH);
   localparam int PA   = addr_bits(PAIR_DEPTH);
   localparam int OFFW = $clog2((MAX_WIDTH + LEVELS + 1) * MAX_CHANNELS) + 1;

   typedef enum logic [1:0] {
      S_DERIVE,
      S_IDLE,
      S_UPDATE
   } state_type;

   // Control and configuration registers.
   state_type                  state_ff;
   logic [WIDTH_REG_W-1:0]     image_width_ff;
   logic [HEIGHT_REG_W-1:0]    image_height_ff;
   logic [CHANNELS_REG_W-1:0]  channels_ff;
   logic [LEVELS_REG_W-1:0]    max_levels_ff;
   logic [LCW-1:0]             nlev_ff;
   logic [LCW-1:0]             dlvl_ff;
   logic [LCW-1:0]             lvl_ff;
   logic                       rsp_valid_ff;

   // Per-level position counters.
   logic [XW-1:0]              col_cnt_ff  [LEVELS];
   logic [YW-1:0]              row_cnt_ff  [LEVELS];
   logic [CW-1:0]              chan_cnt_ff [LEVELS];

   // Per-level sizes and column store offsets from the setup pass.
   logic [WDW-1:0]             lev_w_ff   [LEVELS];
   logic [HDW-1:0]             lev_h_ff   [LEVELS];
   logic [OFFW-1:0]            lev_off_ff [LEVELS];
   logic [WDW-1:0]             dw_ff;
   logic [HDW-1:0]             dh_ff;
   logic [OFFW-1:0]            doff_ff;

   // Level currently being updated.
   logic [XW-1:0]              cur_x_ff;
   logic [YW-1:0]              cur_y_ff;
   logic [CW-1:0]              cur_c_ff;
   logic [WDW-1:0]             cur_w_ff;
   logic [HDW-1:0]             cur_h_ff;
   logic [PA-1:0]              cur_pidx_ff;
   logic [OFFW-1:0]            cur_cidx_ff;
   logic                       cur_cin_ff;
   logic [VW-1:0]              val_ff;

   // Output register payload.
   logic [LEVEL_W-1:0]         rsp_level_ff;
   logic [COLUMN_W-1:0]        rsp_column_ff;
   logic [ROW_W-1:0]           rsp_row_ff;
   logic [CHANNEL_W-1:0]       rsp_channel_ff;
   logic [VALUE_W-1:0]         rsp_value_ff;
   logic                       rsp_last_ff;
   logic                       rsp_done_ff;

   // Combinational signals.
   logic [WDW-1:0]             width_cl;
   logic [HDW-1:0]             height_cl;
   logic [NCW-1:0]             nch;
   logic [LCW-1:0]             lev_cl;
   logic                       csr_known;

   logic [WDW-1:0]             dw_cur;
   logic [WDW-1:0]             dw_next;
   logic [HDW-1:0]             dh_cur;
   logic [HDW-1:0]             dh_next;
   logic [OFFW-1:0]            doff_cur;
   logic [OFFW-1:0]            doff_next;
   logic                       d_stop;

   logic [LCW-1:0]             iss_lvl;
   logic                       iss_valid;
   logic [LIW-1:0]             iss_idx;
   logic [XW-1:0]              iss_x;
   logic [YW-1:0]              iss_y;
   logic [CW-1:0]              iss_c;
   logic [WDW-1:0]             iss_w;
   logic [HDW-1:0]             iss_h;
   logic [OFFW-1:0]            iss_off;
   logic                       iss_done;
   logic [OFFW-1:0]            iss_cidx;
   logic                       iss_cin;
   logic [PA-1:0]              iss_pidx;

   logic                       cur_xlast;
   logic                       cur_ylast;
   logic                       cur_clast;
   logic                       cur_col;
   logic                       cur_done;
   logic                       col_we;
   logic                       cur_img_done;
   logic [PW-1:0]              pair_rd;
   logic [PW-1:0]              col_rd;
   logic [PW-1:0]              col_top;
   logic [PW-1:0]              pair_in;
   logic [SW-1:0]              sum_in;
   logic [VW-1:0]              avg;
   logic [XW-1:0]              x_in;
   logic [YW-1:0]              y_in;
   logic [CW-1:0]              c_in;

   logic                       slot_free;
   logic                       advance;
   logic                       go_next;
   logic                       accept;
   logic                       issue;

   // Clamp the registers to their legal ranges.
   always_comb begin
      if (image_width_ff == '0) begin
         width_cl = WDW'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         width_cl = WDW'(MAX_WIDTH);
      end else begin
         width_cl = WDW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         height_cl = HDW'(1);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         height_cl = HDW'(MAX_HEIGHT);
      end else begin
         height_cl = HDW'(image_height_ff);
      end
      if (channels_ff == '0) begin
         nch = NCW'(1);
      end else if (32'(channels_ff) > MAX_CHANNELS) begin
         nch = NCW'(MAX_CHANNELS);
      end else begin
         nch = NCW'(channels_ff);
      end
      if (max_levels_ff == '0) begin
         lev_cl = LCW'(1);
      end else if (32'(max_levels_ff) > LEVELS) begin
         lev_cl = LCW'(LEVELS);
      end else begin
         lev_cl = LCW'(max_levels_ff);
      end
   end

   // Decode of the register index; writes beyond the list are ignored.
   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH:  csr_known = 1'b1;
         REG_IMAGE_HEIGHT: csr_known = 1'b1;
         REG_CHANNELS:     csr_known = 1'b1;
         REG_MAX_LEVELS:   csr_known = 1'b1;
         default:          csr_known = 1'b0;
      endcase
   end

   // Setup pass: one level per cycle, halving the size and stacking offsets.
   always_comb begin
      dw_cur    = (dlvl_ff == '0) ? width_cl : dw_ff;
      dh_cur    = (dlvl_ff == '0) ? height_cl : dh_ff;
      doff_cur  = (dlvl_ff == '0) ? '0 : doff_ff;
      dw_next   = WDW'((32'(dw_cur) + 1) >> 1);
      dh_next   = HDW'((32'(dh_cur) + 1) >> 1);
      doff_next = doff_cur + OFFW'(dw_next) * OFFW'(nch);
      d_stop    = (32'(dw_next) + 32'(dh_next) <= 2) || (32'(dlvl_ff) + 1 >= 32'(lev_cl));
   end

   // Lookup of the level whose RAM reads are issued next.
   always_comb begin
      iss_lvl   = (state_ff == S_UPDATE) ? LCW'(32'(lvl_ff) + 1) : '0;
      iss_valid = iss_lvl < nlev_ff;
      iss_idx   = iss_valid ? iss_lvl[LIW-1:0] : '0;
      iss_x     = col_cnt_ff[iss_idx];
      iss_y     = row_cnt_ff[iss_idx];
      iss_c     = chan_cnt_ff[iss_idx];
      iss_w     = lev_w_ff[iss_idx];
      iss_h     = lev_h_ff[iss_idx];
      iss_off   = lev_off_ff[iss_idx];
      iss_done  = (iss_x[0] || (32'(iss_x) + 1 >= 32'(iss_w)))
                  && (iss_y[0] || (32'(iss_y) + 1 >= 32'(iss_h)));
      iss_cidx  = iss_off + OFFW'(iss_x >> 1) * OFFW'(nch) + OFFW'(iss_c);
      iss_cin   = 32'(iss_cidx) < COL_DEPTH;
      iss_pidx  = PA'(32'(iss_idx) * MAX_CHANNELS + 32'(iss_c));
   end

   // Read-modify-write of the current level.
   always_comb begin
      cur_xlast = 32'(cur_x_ff) + 1 >= 32'(cur_w_ff);
      cur_ylast = 32'(cur_y_ff) + 1 >= 32'(cur_h_ff);
      cur_clast = 32'(cur_c_ff) + 1 >= 32'(nch);
      cur_col   = cur_x_ff[0] || cur_xlast;
      cur_done  = cur_col && (cur_y_ff[0] || cur_ylast);
      col_we    = cur_col && !cur_y_ff[0] && cur_cin_ff;
      pair_in   = cur_x_ff[0] ? pair_rd + PW'(val_ff) : PW'(val_ff);
      col_top   = cur_cin_ff ? col_rd : '0;
      sum_in    = cur_y_ff[0] ? SW'(col_top) + SW'(pair_in) : SW'(pair_in);
      avg       = VW'(sum_in >> 2);
      cur_img_done = (32'(lvl_ff) + 1 == 32'(nlev_ff))
                     && (32'(cur_x_ff >> 1) + 1 >= ((32'(cur_w_ff) + 1) >> 1))
                     && (32'(cur_y_ff >> 1) + 1 >= ((32'(cur_h_ff) + 1) >> 1))
                     && cur_clast;
   end

   // Next position of the current level: channel, then column, then row.
   always_comb begin
      x_in = cur_x_ff;
      y_in = cur_y_ff;
      c_in = CW'(32'(cur_c_ff) + 1);
      if (cur_clast) begin
         c_in = '0;
         if (cur_xlast) begin
            x_in = '0;
            y_in = cur_ylast ? '0 : YW'(32'(cur_y_ff) + 1);
         end else begin
            x_in = XW'(32'(cur_x_ff) + 1);
         end
      end
   end

   // Handshake and sequencing.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign advance   = (state_ff == S_UPDATE) && (!cur_done || slot_free);
   assign go_next   = cur_done && iss_valid;
   assign accept    = (state_ff == S_IDLE) && req_valid;
   assign issue     = accept || (advance && go_next);

   // Running horizontal pair sums, one entry per level and channel.
   bdp_ram #(
      .WIDTH (PW),
      .DEPTH (PAIR_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (cur_pidx_ff),
      .wr_data (pair_in),
      .rd_en   (issue),
      .rd_addr (iss_pidx),
      .rd_data (pair_rd)
   );

   // Even-row pair sums, one entry per level, output column and channel.
   bdp_ram #(
      .WIDTH (PW),
      .DEPTH (COL_DEPTH)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (advance && col_we),
      .wr_addr (cur_cidx_ff[CA-1:0]),
      .wr_data (pair_in),
      .rd_en   (issue),
      .rd_addr (iss_cidx[CA-1:0]),
      .rd_data (col_rd)
   );

   // State machine, counters, configuration and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_DERIVE;
         dlvl_ff         <= '0;
         nlev_ff         <= LCW'(1);
         lvl_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         image_width_ff  <= RESET_IMAGE_WIDTH;
         image_height_ff <= RESET_IMAGE_HEIGHT;
         channels_ff     <= RESET_CHANNELS;
         max_levels_ff   <= RESET_MAX_LEVELS;
         for (int i = 0; i < LEVELS; i++) begin
            col_cnt_ff[i]  <= '0;
            row_cnt_ff[i]  <= '0;
            chan_cnt_ff[i] <= '0;
         end
      end else begin
         // The output register empties on a transfer.
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_DERIVE: begin
               lev_w_ff[dlvl_ff[LIW-1:0]]   <= dw_cur;
               lev_h_ff[dlvl_ff[LIW-1:0]]   <= dh_cur;
               lev_off_ff[dlvl_ff[LIW-1:0]] <= doff_cur;
               nlev_ff <= LCW'(32'(dlvl_ff) + 1);
               if (d_stop) begin
                  state_ff <= S_IDLE;
               end else begin
                  dlvl_ff <= LCW'(32'(dlvl_ff) + 1);
                  dw_ff   <= dw_next;
                  dh_ff   <= dh_next;
                  doff_ff <= doff_next;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  val_ff   <= VW'(req_sample) << FRAC_BITS;
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               if (advance) begin
                  col_cnt_ff[lvl_ff[LIW-1:0]]  <= x_in;
                  row_cnt_ff[lvl_ff[LIW-1:0]]  <= y_in;
                  chan_cnt_ff[lvl_ff[LIW-1:0]] <= c_in;
                  if (cur_done) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_level_ff   <= LEVEL_W'(32'(lvl_ff) + 1);
                     rsp_column_ff  <= COLUMN_W'(cur_x_ff >> 1);
                     rsp_row_ff     <= ROW_W'(cur_y_ff >> 1);
                     rsp_channel_ff <= CHANNEL_W'(cur_c_ff);
                     rsp_value_ff   <= VALUE_W'(avg);
                     rsp_last_ff    <= !(go_next && iss_done);
                     rsp_done_ff    <= cur_img_done;
                  end
                  // The reduced value feeds the next level.
                  if (go_next) begin
                     val_ff <= avg;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // Capture the level whose RAM reads go out this cycle.
         if (issue) begin
            lvl_ff      <= iss_lvl;
            cur_x_ff    <= iss_x;
            cur_y_ff    <= iss_y;
            cur_c_ff    <= iss_c;
            cur_w_ff    <= iss_w;
            cur_h_ff    <= iss_h;
            cur_pidx_ff <= iss_pidx;
            cur_cidx_ff <= iss_cidx;
            cur_cin_ff  <= iss_cin;
         end

         // A register write restarts the image and the setup pass.
         if (csr_wr_en) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  image_width_ff  <= csr_data[WIDTH_REG_W-1:0];
               REG_IMAGE_HEIGHT: image_height_ff <= csr_data[HEIGHT_REG_W-1:0];
               REG_CHANNELS:     channels_ff     <= csr_data[CHANNELS_REG_W-1:0];
               REG_MAX_LEVELS:   max_levels_ff   <= csr_data[LEVELS_REG_W-1:0];
               default: begin
               end
            endcase
            if (csr_known) begin
               state_ff <= S_DERIVE;
               dlvl_ff  <= '0;
               for (int i = 0; i < LEVELS; i++) begin
                  col_cnt_ff[i]  <= '0;
                  row_cnt_ff[i]  <= '0;
                  chan_cnt_ff[i] <= '0;
               end
            end
         end
      end
   end

   // Port drivers.
   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_column      = rsp_column_ff;
   assign rsp_row         = rsp_row_ff;
   assign rsp_channel     = rsp_channel_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_image_done  = rsp_done_ff;

endmodule
